### design/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

    // Default sizing
    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 32;

    // Fixed field widths
    localparam int MODE_W   = 4;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 6;
    localparam int COUNT_W  = 7;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK    = 4'd0,
        MODE_PUSH_FRONT   = 4'd1,
        MODE_POP_BACK     = 4'd2,
        MODE_POP_FRONT    = 4'd3,
        MODE_INSERT       = 4'd4,
        MODE_ERASE        = 4'd5,
        MODE_FIND         = 4'd6,
        MODE_REMOVE_FIRST = 4'd7,
        MODE_REMOVE_ALL   = 4'd8,
        MODE_CLEAR        = 4'd9
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_SCAN,
        ST_PUT,
        ST_FINISH
    } t_state;

endpackage

### design/sle_cmd_if.sv
`timescale 1ns / 1ps

interface sle_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [sle_pkg::MODE_W-1:0]          mode;
    logic [sle_pkg::POS_W-1:0]           position;
    logic signed [sle_pkg::VALUE_W-1:0]  value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface

### design/sle_res_if.sv
`timescale 1ns / 1ps

interface sle_res_if;
    logic                           valid;
    logic                           ready;
    logic [sle_pkg::STATUS_W-1:0]   status;
    logic [sle_pkg::FOUND_W-1:0]    found_index;
    logic [sle_pkg::COUNT_W-1:0]    entry_count;
    logic                           is_empty;

    modport source (output valid, status, found_index, entry_count, is_empty, input ready);
    modport sink   (input valid, status, found_index, entry_count, is_empty, output ready);
endinterface

### design/sequential_list_engine.sv
`timescale 1ns / 1ps
// Flow: a command that reads no entry goes from idle straight to the finish state, or through
// the put state when it writes one word; a shift, search or compaction walks the list with one
// list read per cycle, an insert that shifts goes on to the put state, and a remove-first that
// shifts goes on to a shift down; the result is loaded in the finish state once the output is free.
// Throughput: one command at a time; the next is taken once the previous result is loaded.
// Reset (synchronous, active low) empties the list; memory contents are not cleared.
module sequential_list_engine #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sle_pkg::DATA_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sle_cmd_if.sink    i_cmd,
    sle_res_if.source  o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
    localparam int FW = sle_pkg::FOUND_W;
    localparam int OW = sle_pkg::COUNT_W;

    // List storage
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Control and command state
    sle_pkg::t_state       r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    sle_pkg::t_mode        r_mode, n_mode;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    sle_pkg::t_status      r_status, n_status;
    logic [AW-1:0]         r_found, n_found;
    logic [CW-1:0]         r_res_cnt, n_res_cnt;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_last, n_last;
    logic [AW-1:0]         r_pidx, n_pidx;
    logic                  r_issue, n_issue;
    logic                  r_pend, n_pend;
    logic [CW-1:0]         r_w, n_w;

    // Result register
    logic                  r_out_valid, n_out_valid;
    sle_pkg::t_status      r_out_status, n_out_status;
    logic [AW-1:0]         r_out_found, n_out_found;
    logic [CW-1:0]         r_out_cnt, n_out_cnt;
    logic                  r_out_empty, n_out_empty;

    // Memory port controls
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [PW-1:0]         sel_pos;
    logic                  is_full;
    logic                  is_none;
    logic                  match;
    logic                  scan_end;
    logic                  out_free;

    assign pos_ext  = PW'(i_cmd.position);
    assign cnt_ext  = PW'(r_count);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_none  = (r_count == '0);
    assign match    = (r_rd_data == r_val);
    assign scan_end = r_pend && (r_pidx == r_last);
    assign out_free = !r_out_valid || o_res.ready;

    assign i_cmd.ready       = (r_state == sle_pkg::ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.found_index = FW'(r_out_found);
    assign o_res.entry_count = OW'(r_out_cnt);
    assign o_res.is_empty    = r_out_empty;

    // Next state, memory walk and result load
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mode       = r_mode;
        n_val        = r_val;
        n_status     = r_status;
        n_found      = r_found;
        n_res_cnt    = r_res_cnt;
        n_ptr        = r_ptr;
        n_last       = r_last;
        n_pidx       = r_pidx;
        n_issue      = r_issue;
        n_pend       = 1'b0;
        n_w          = r_w;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_cnt    = r_out_cnt;
        n_out_empty  = r_out_empty;
        rd_en        = 1'b0;
        rd_addr      = r_ptr;
        wr_en        = 1'b0;
        wr_addr      = r_pidx;
        wr_data      = r_rd_data;
        sel_pos      = '0;

        // Issue one read per cycle while walking the list
        if (r_state inside {sle_pkg::ST_SHIFT_UP, sle_pkg::ST_SHIFT_DN, sle_pkg::ST_SCAN}) begin
            rd_en  = r_issue;
            n_pend = r_issue;
            n_pidx = r_ptr;
            if (r_issue) begin
                if (r_ptr == r_last) begin
                    n_issue = 1'b0;
                end else if (r_state == sle_pkg::ST_SHIFT_UP) begin
                    n_ptr = r_ptr - 1'b1;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
        end

        case (r_state)
            sle_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_mode    = sle_pkg::t_mode'(i_cmd.mode);
                    n_val     = DATA_WIDTH'($unsigned(i_cmd.value));
                    n_status  = sle_pkg::STAT_OK;
                    n_found   = '0;
                    n_res_cnt = r_count;
                    n_w       = '0;
                    n_issue   = 1'b0;
                    n_state   = sle_pkg::ST_FINISH;
                    case (sle_pkg::t_mode'(i_cmd.mode))
                        sle_pkg::MODE_PUSH_BACK, sle_pkg::MODE_PUSH_FRONT,
                        sle_pkg::MODE_INSERT: begin
                            if (sle_pkg::t_mode'(i_cmd.mode) == sle_pkg::MODE_PUSH_BACK) begin
                                sel_pos = cnt_ext;
                            end else if (sle_pkg::t_mode'(i_cmd.mode) == sle_pkg::MODE_INSERT) begin
                                sel_pos = pos_ext;
                            end
                            if (is_full) begin
                                n_status = sle_pkg::STAT_FULL;
                            end else if (sel_pos > cnt_ext) begin
                                n_status = sle_pkg::STAT_BAD_POS;
                            end else begin
                                n_res_cnt = r_count + 1'b1;
                                n_last    = AW'(sel_pos);
                                if (sel_pos == cnt_ext) begin
                                    n_state = sle_pkg::ST_PUT;
                                end else begin
                                    n_ptr   = AW'(r_count - 1'b1);
                                    n_issue = 1'b1;
                                    n_state = sle_pkg::ST_SHIFT_UP;
                                end
                            end
                        end
                        sle_pkg::MODE_POP_BACK, sle_pkg::MODE_POP_FRONT,
                        sle_pkg::MODE_ERASE: begin
                            if (sle_pkg::t_mode'(i_cmd.mode) == sle_pkg::MODE_POP_BACK) begin
                                sel_pos = cnt_ext - 1'b1;
                            end else if (sle_pkg::t_mode'(i_cmd.mode) == sle_pkg::MODE_ERASE) begin
                                sel_pos = pos_ext;
                            end
                            if (is_none) begin
                                n_status = sle_pkg::STAT_EMPTY;
                            end else if (sel_pos >= cnt_ext) begin
                                n_status = sle_pkg::STAT_BAD_POS;
                            end else begin
                                n_res_cnt = r_count - 1'b1;
                                if (sel_pos != cnt_ext - 1'b1) begin
                                    n_ptr   = AW'(sel_pos + 1'b1);
                                    n_last  = AW'(r_count - 1'b1);
                                    n_issue = 1'b1;
                                    n_state = sle_pkg::ST_SHIFT_DN;
                                end
                            end
                        end
                        sle_pkg::MODE_FIND, sle_pkg::MODE_REMOVE_FIRST,
                        sle_pkg::MODE_REMOVE_ALL: begin
                            if (is_none) begin
                                n_status = sle_pkg::STAT_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_last  = AW'(r_count - 1'b1);
                                n_issue = 1'b1;
                                n_state = sle_pkg::ST_SCAN;
                            end
                        end
                        sle_pkg::MODE_CLEAR: begin
                            n_res_cnt = '0;
                        end
                        default: begin
                            n_res_cnt = r_count;
                        end
                    endcase
                end
            end

            // Move each entry one place up, top first
            sle_pkg::ST_SHIFT_UP: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx + 1'b1;
                    if (!r_issue) begin
                        n_state = sle_pkg::ST_PUT;
                    end
                end
            end

            // Write the new word into the opened slot
            sle_pkg::ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_last;
                wr_data = r_val;
                n_state = sle_pkg::ST_FINISH;
            end

            // Move each entry one place down, bottom first
            sle_pkg::ST_SHIFT_DN: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pidx - 1'b1;
                    if (!r_issue) begin
                        n_state = sle_pkg::ST_FINISH;
                    end
                end
            end

            // Compare each entry against the search word
            sle_pkg::ST_SCAN: begin
                if (r_pend) begin
                    case (r_mode)
                        sle_pkg::MODE_FIND: begin
                            if (match) begin
                                n_found = r_pidx;
                                n_issue = 1'b0;
                                n_pend  = 1'b0;
                                n_state = sle_pkg::ST_FINISH;
                            end else if (scan_end) begin
                                n_status = sle_pkg::STAT_NOT_FOUND;
                                n_state  = sle_pkg::ST_FINISH;
                            end
                        end
                        sle_pkg::MODE_REMOVE_FIRST: begin
                            if (match) begin
                                n_found   = r_pidx;
                                n_res_cnt = r_count - 1'b1;
                                if (scan_end) begin
                                    n_issue = 1'b0;
                                    n_state = sle_pkg::ST_FINISH;
                                end else begin
                                    // drop the read in flight and close the gap
                                    n_ptr   = r_pidx + 1'b1;
                                    n_issue = 1'b1;
                                    n_pend  = 1'b0;
                                    n_state = sle_pkg::ST_SHIFT_DN;
                                end
                            end else if (scan_end) begin
                                n_status = sle_pkg::STAT_NOT_FOUND;
                                n_state  = sle_pkg::ST_FINISH;
                            end
                        end
                        default: begin
                            // compact: keep entries that differ
                            if (!match) begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_w);
                                n_w     = r_w + 1'b1;
                            end
                            if (scan_end) begin
                                n_res_cnt = n_w;
                                n_state   = sle_pkg::ST_FINISH;
                                if (n_w == r_count) begin
                                    n_status = sle_pkg::STAT_NOT_FOUND;
                                end
                            end
                        end
                    endcase
                end
            end

            // Hand the result to the output register
            sle_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_cnt    = r_res_cnt;
                    n_out_empty  = (r_res_cnt == '0);
                    n_count      = r_res_cnt;
                    n_state      = sle_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sle_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::ST_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_val        <= n_val;
        r_status     <= n_status;
        r_found      <= n_found;
        r_res_cnt    <= n_res_cnt;
        r_ptr        <= n_ptr;
        r_last       <= n_last;
        r_pidx       <= n_pidx;
        r_w          <= n_w;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_cnt    <= n_out_cnt;
        r_out_empty  <= n_out_empty;
    end

    // List memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

### design/sle_chk.sv
`timescale 1ns / 1ps

module sle_chk #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [sle_pkg::STATUS_W-1:0] i_res_status,
    input logic [sle_pkg::FOUND_W-1:0]  i_res_found_index,
    input logic [sle_pkg::COUNT_W-1:0]  i_res_entry_count,
    input logic                         i_res_is_empty
);

    localparam int OW = sle_pkg::COUNT_W;

    // Hold a stalled result's status, index and count unchanged
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_status)
            && $stable(i_res_found_index) && $stable(i_res_entry_count))
        else $error("result changed while stalled");

    // A full rejection reports a full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == sle_pkg::STAT_FULL) |->
            (i_res_entry_count == OW'(DEPTH)))
        else $error("full status with count below depth");

    // An empty rejection reports an empty list
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == sle_pkg::STAT_EMPTY) |->
            i_res_is_empty && (i_res_entry_count == '0))
        else $error("empty status on a non-empty list");

    // A match index only comes with a successful command
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_found_index != '0) |->
            (i_res_status == sle_pkg::STAT_OK) && !i_res_is_empty)
        else $error("found index on a failed command");

endmodule

bind sequential_list_engine sle_chk #(.DEPTH(DEPTH)) u_sle_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_found_index (o_res.found_index),
    .i_res_entry_count (o_res.entry_count),
    .i_res_is_empty    (o_res.is_empty)
);
